// ===== rtl/tmt_pkg.sv =====
// Shared types, constants and generator functions for the TinyMT32 block.
package tmt_pkg;

  // Generator parameters
  localparam logic [31:0] MAT1      = 32'h8f7011ee;
  localparam logic [31:0] MAT2      = 32'hfc78ff1f;
  localparam logic [31:0] TMAT      = 32'h3793fdff;
  localparam logic [31:0] INIT_MULT = 32'h6c078965;
  localparam logic [31:0] LOW31     = 32'h7fffffff;

  // Replacement words for a degenerate seeded state
  localparam logic [31:0] CH_T = 32'h0000_0054;
  localparam logic [31:0] CH_I = 32'h0000_0049;
  localparam logic [31:0] CH_N = 32'h0000_004e;
  localparam logic [31:0] CH_Y = 32'h0000_0059;

  // Seeding and skip structure
  localparam int SEED_ROUNDS     = 7;
  localparam int SEED_STEPS      = 8;
  localparam int ROUND_W         = 3;
  localparam int SKIP_STEP_BITS  = 7;
  localparam int STEP_CNT_W      = SKIP_STEP_BITS;
  localparam int SKIP_HI_W       = 32 - SKIP_STEP_BITS;
  localparam int JUMP_LEVELS_MAX = 25;
  localparam int ROM_IDX_W       = 5;
  localparam int POLY_W          = 128;
  localparam int JCNT_W          = 7;

  // Small queues on both sides of the sequencer
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_NEXT = 2'd2,
    KIND_SKIP = 2'd3
  } kind_t;

  // Classified command word: seed and skip count sit in the low 32 bits
  typedef struct packed {
    kind_t        kind;
    logic [127:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_MIX,
    ST_SEED_FIX,
    ST_STEP,
    ST_LEVEL,
    ST_JUMP,
    ST_JUMP_END
  } core_state_t;

  // One generator step on {w3, w2, w1, w0}
  function automatic logic [127:0] tmt_step(input logic [127:0] s);
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] m;
    logic [127:0] r;
    x = (s[31:0] & LOW31) ^ s[63:32] ^ s[95:64];
    x = x ^ {x[30:0], 1'b0};
    y = s[127:96];
    y = y ^ {1'b0, y[31:1]} ^ x;
    m = {32{y[0]}};
    r[31:0]   = s[63:32];
    r[63:32]  = s[95:64] ^ (m & MAT1);
    r[95:64]  = x ^ {y[21:0], 10'd0} ^ (m & MAT2);
    r[127:96] = y;
    return r;
  endfunction

  // Output tempering of a state
  function automatic logic [31:0] tmt_temper(input logic [127:0] s);
    logic [31:0] t0;
    logic [31:0] t1;
    t1 = s[31:0] + {8'd0, s[95:72]};
    t0 = s[127:96] ^ t1;
    if (t1[0]) begin
      t0 = t0 ^ TMAT;
    end
    return t0;
  endfunction

  // Jump polynomials, bit j is consumed at jump step j (lower half first)
  function automatic logic [POLY_W-1:0] tmt_jump_row(input logic [ROM_IDX_W-1:0] idx);
    logic [POLY_W-1:0] r;
    case (idx)
      5'd0:  r = {64'h68f6c067369601df, 64'h9654f148a90fcec5};
      5'd1:  r = {64'h3acf552103dbbf73, 64'hb9e15caa5f8d586b};
      5'd2:  r = {64'h2528779341278769, 64'h149df0a3ce8a313d};
      5'd3:  r = {64'h5ab81fcd13ccd9fa, 64'hce6673b3d158340e};
      5'd4:  r = {64'h3f8285b29763f1a0, 64'h84c1c823c273e23b};
      5'd5:  r = {64'h2e1bd6473d093826, 64'h61def4964ec4ab34};
      5'd6:  r = {64'h33ae14e5d2005a71, 64'h334a0fe77ab182de};
      5'd7:  r = {64'h0e06f5b1e69f0174, 64'hba589ce43d24301d};
      5'd8:  r = {64'h0586e1d6b2670a75, 64'h86bf0979d37c9a1e};
      5'd9:  r = {64'h55d7db08d9d6e575, 64'h6f1cde00c5428bd5};
      5'd10: r = {64'h457372c828f32370, 64'h55bf4c862403495b};
      5'd11: r = {64'h7d9a80f7f39cdc7f, 64'ha37711f1e4e489c5};
      5'd12: r = {64'h7c5c99ea483c815a, 64'h9f1173b680f6752e};
      5'd13: r = {64'h658cd2f421d18c04, 64'h41fbd20233bcb628};
      5'd14: r = {64'h694898799783db46, 64'hc8fc1f0f485cc220};
      5'd15: r = {64'h4cf6c5ecc4826e0b, 64'h8e695f0109724eb6};
      5'd16: r = {64'h2a5eaf3a194065dc, 64'hf9b4e14b65c67175};
      5'd17: r = {64'h475fa9dca8a63e5a, 64'hf2272003ed156055};
      5'd18: r = {64'h73ab53c0e246197f, 64'h97191167e296db49};
      5'd19: r = {64'h20999170716ca869, 64'h203777ca7d356342};
      5'd20: r = {64'h5dcb2d78b3e9ca0f, 64'h7222f0529a9dd99c};
      5'd21: r = {64'h197365ac9569a8b4, 64'h6dd7a644730f081a};
      5'd22: r = {64'h2a472d665ef39ef4, 64'h0d7382718dc46f8f};
      5'd23: r = {64'h74284a9019b6eae3, 64'hafb1a319fcfd8eb7};
      5'd24: r = {64'h40afea91e9ad4b2c, 64'h58440d15ded1d336};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tmt_front.sv =====
// Input side: classifies incoming words and queues them as commands.
module tmt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_kind,
  input  logic [31:0]   in_seed,
  input  logic [31:0]   in_word0,
  input  logic [31:0]   in_word1,
  input  logic [31:0]   in_word2,
  input  logic [31:0]   in_word3,
  input  logic [31:0]   in_count,
  output tmt_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import tmt_pkg::*;

  cmd_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              wr_en;
  logic              rd_en;
  cmd_t              cls;

  // Pack only the fields each kind uses
  always_comb begin
    cls.kind = kind_t'(in_kind);
    cls.data = '0;
    case (kind_t'(in_kind))
      KIND_SEED: cls.data = {96'd0, in_seed};
      KIND_LOAD: cls.data = {in_word3, in_word2, in_word1, in_word0};
      KIND_SKIP: cls.data = {96'd0, in_count};
      default:   cls.data = '0;
    endcase
  end

  // Queue bookkeeping
  assign in_full   = (cnt_r == QCNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Command storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== rtl/tmt_core.sv =====
// Sequencer: runs seeding, stepping, tempering and polynomial jumps.
module tmt_core #(
  parameter int JUMP_LEVELS = tmt_pkg::JUMP_LEVELS_MAX
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tmt_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output logic [31:0]   res_value
);
  import tmt_pkg::*;

  localparam int LVL_W = $clog2(JUMP_LEVELS + 1);

  core_state_t            state_r, state_nxt;
  logic [127:0]           words_r, words_nxt;
  logic [127:0]           acc_r, acc_nxt;
  logic [POLY_W-1:0]      poly_r, poly_nxt;
  logic [31:0]            prod_r, prod_nxt;
  logic [ROUND_W-1:0]     round_r, round_nxt;
  logic [STEP_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SKIP_HI_W-1:0]   skip_r, skip_nxt;
  logic [LVL_W-1:0]       level_r, level_nxt;
  logic [JCNT_W-1:0]      jcnt_r, jcnt_nxt;

  logic [127:0] step_w;
  logic [1:0]   src_idx;
  logic [1:0]   dst_idx;
  logic [31:0]  mix_src;
  logic [31:0]  mix_word;
  logic         is_next;
  logic         levels_done;
  logic         seed_zero;

  assign step_w      = tmt_step(words_r);
  assign res_value   = tmt_temper(step_w);
  assign is_next     = (cmd.kind == KIND_NEXT);
  assign levels_done = (skip_r == '0) || (level_r == LVL_W'(JUMP_LEVELS));
  assign seed_zero   = ((words_r[31:0] & LOW31) == '0) && (words_r[127:32] == '0);

  // Seed round operands: source word (i-1), destination word i
  assign src_idx  = 2'(round_r - 1'b1);
  assign dst_idx  = round_r[1:0];
  assign mix_word = words_r[32*src_idx +: 32];
  assign mix_src  = mix_word ^ {30'd0, mix_word[31:30]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            KIND_SEED: state_nxt = ST_SEED_MUL;
            KIND_SKIP: state_nxt = ST_STEP;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEED_MUL: state_nxt = ST_SEED_MIX;
      ST_SEED_MIX: begin
        state_nxt = (round_r == ROUND_W'(SEED_ROUNDS)) ? ST_SEED_FIX : ST_SEED_MUL;
      end
      ST_SEED_FIX: state_nxt = ST_STEP;
      ST_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (levels_done) begin
          state_nxt = ST_IDLE;
        end else if (skip_r[0]) begin
          state_nxt = ST_JUMP;
        end
      end
      ST_JUMP: begin
        if (jcnt_r == '1) begin
          state_nxt = ST_JUMP_END;
        end
      end
      ST_JUMP_END: state_nxt = ST_LEVEL;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Queue handshakes: a next word needs room for its result
  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_pop  = cmd_valid && (!is_next || !res_full);
        res_push = cmd_valid && is_next && !res_full;
      end
      default: begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  // Datapath
  always_comb begin
    words_nxt = words_r;
    acc_nxt   = acc_r;
    poly_nxt  = poly_r;
    prod_nxt  = prod_r;
    round_nxt = round_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    level_nxt = level_r;
    jcnt_nxt  = jcnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.kind)
            KIND_SEED: begin
              words_nxt = {TMAT, MAT2, MAT1, cmd.data[31:0]};
              round_nxt = ROUND_W'(1);
            end
            KIND_LOAD: words_nxt = cmd.data;
            KIND_NEXT: words_nxt = step_w;
            default: begin
              cnt_nxt   = cmd.data[STEP_CNT_W-1:0];
              skip_nxt  = cmd.data[31:SKIP_STEP_BITS];
              level_nxt = '0;
            end
          endcase
        end
      end
      ST_SEED_MUL: prod_nxt = INIT_MULT * mix_src;
      ST_SEED_MIX: begin
        words_nxt[32*dst_idx +: 32] = words_r[32*dst_idx +: 32]
                                      ^ (prod_r + {{(32-ROUND_W){1'b0}}, round_r});
        round_nxt = round_r + 1'b1;
      end
      ST_SEED_FIX: begin
        if (seed_zero) begin
          words_nxt = {CH_Y, CH_N, CH_I, CH_T};
        end
        cnt_nxt  = STEP_CNT_W'(SEED_STEPS);
        skip_nxt = '0;
      end
      ST_STEP: begin
        if (cnt_r != '0) begin
          words_nxt = step_w;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_LEVEL: begin
        if (!levels_done) begin
          skip_nxt  = skip_r >> 1;
          level_nxt = level_r + 1'b1;
          if (skip_r[0]) begin
            poly_nxt = tmt_jump_row(ROM_IDX_W'(level_r));
            acc_nxt  = '0;
            jcnt_nxt = '0;
          end
        end
      end
      ST_JUMP: begin
        if (poly_r[0]) begin
          acc_nxt = acc_r ^ words_r;
        end
        words_nxt = step_w;
        poly_nxt  = poly_r >> 1;
        jcnt_nxt  = jcnt_r + 1'b1;
      end
      ST_JUMP_END: words_nxt = acc_r;
      default: ;
    endcase
  end

  // Control and generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      words_r <= '0;
      acc_r   <= '0;
      round_r <= '0;
      cnt_r   <= '0;
      skip_r  <= '0;
      level_r <= '0;
      jcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      words_r <= words_nxt;
      acc_r   <= acc_nxt;
      round_r <= round_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      level_r <= level_nxt;
      jcnt_r  <= jcnt_nxt;
    end
  end

  // Operand registers
  always_ff @(posedge clk) begin
    poly_r <= poly_nxt;
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/tmt_outq.sv =====
// Result side: two-entry queue of tempered output words.
module tmt_outq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_push,
  input  logic [31:0] res_value,
  output logic        res_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_value
);
  import tmt_pkg::*;

  logic [31:0]       mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              wr_en;
  logic              rd_en;

  assign res_full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign out_value = mem_r[rd_ptr_r];
  assign wr_en     = res_push && !res_full;
  assign rd_en     = out_pop && !out_empty;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Word storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= res_value;
    end
  end

endmodule

// ===== rtl/tinymt32_generator_with_jump.sv =====
// TinyMT32 generator with skip-ahead: top level.
// Next word: its result is written into the output queue as the sequencer takes it; one next
// word per cycle while the sequencer is idle and the output queue has room. Seed: 7 rounds of
// a multiply and a mix state (one multiplier), then a fix-up state and the seeding steps. Skip:
// low 7 count bits as steps, a polynomial jump per set bit above. Queues of 2 entries per side.
// Reset clears both queues and the sequencer; the generator state reads as all zero.
module tinymt32_generator_with_jump #(
  parameter int JUMP_LEVELS = tmt_pkg::JUMP_LEVELS_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_seed,
  input  logic [31:0] in_word0,
  input  logic [31:0] in_word1,
  input  logic [31:0] in_word2,
  input  logic [31:0] in_word3,
  input  logic [31:0] in_count,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_value
);
  import tmt_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  logic        res_full;
  logic        res_push;
  logic [31:0] res_value;

  tmt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_kind   (in_kind),
    .in_seed   (in_seed),
    .in_word0  (in_word0),
    .in_word1  (in_word1),
    .in_word2  (in_word2),
    .in_word3  (in_word3),
    .in_count  (in_count),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  tmt_core #(
    .JUMP_LEVELS (JUMP_LEVELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_value (res_value)
  );

  tmt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_value (res_value),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_value (out_value)
  );

  // A result is never written into a full output queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into full output queue");

  // The sequencer only takes a command that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

  // Only a next word produces a result
  a_push_next: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (cmd_pop && cmd.kind == KIND_NEXT))
    else $error("result produced by a non-next command");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
